// ----- sv/bup_pkg.sv -----
// Shared types, constants and field layout of the box union point test block.
package bup_pkg;

	localparam int MAX_BOXES_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int CFG_W         = 5;
	localparam int IDX_IN_W      = 4;
	localparam int CMD_W         = 2;
	localparam int DIM_W         = 2;
	localparam int NUM_AXES      = 3;
	localparam int BOX_WORDS     = 2 * NUM_AXES;
	localparam int BOX_W         = BOX_WORDS * COORD_W;

	// Request payload layout, lowest bit first.
	localparam int IN_IDX_LSB    = 0;
	localparam int IN_BOX_LSB    = IN_IDX_LSB + IDX_IN_W;
	localparam int IN_PT_LSB     = IN_BOX_LSB + BOX_W;
	localparam int IN_USED_W     = IN_PT_LSB + NUM_AXES * COORD_W;
	localparam int IN_W          = ((IN_USED_W + 7) / 8) * 8;

	// Result payload layout, lowest bit first.
	localparam int OUT_INSIDE    = 0;
	localparam int OUT_BND_LSB   = 1;
	localparam int OUT_DIM_LSB   = OUT_BND_LSB + BOX_W;
	localparam int OUT_USED_W    = OUT_DIM_LSB + DIM_W;
	localparam int OUT_W         = ((OUT_USED_W + 7) / 8) * 8;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_POINT = 2'd1,
		CMD_BOUND = 2'd2
	} cmd_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic kind_bound;
		logic load;
		logic rd_en;
		logic emit;
	} bup_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic nb_zero;
		logic rd_last;
		logic out_free;
	} bup_stat_t;

endpackage

// ----- sv/bup_datapath.sv -----
// Box table, walk counter, hit and bounding box accumulators, result register.
module bup_datapath #(
	parameter int MAX_BOXES = bup_pkg::MAX_BOXES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [bup_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic [bup_pkg::IN_W-1:0]   s_tdata,
	input  bup_pkg::bup_ctl_t          ctl,
	output bup_pkg::bup_stat_t         stat,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [bup_pkg::OUT_W-1:0]  m_tdata
);

	localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int CW    = bup_pkg::COORD_W;
	localparam int NA    = bup_pkg::NUM_AXES;

	logic [bup_pkg::CFG_W-1:0] box_count_q;
	logic [CNT_W-1:0]          nb;

	logic [bup_pkg::BOX_W-1:0] mem [MAX_BOXES];
	logic [bup_pkg::BOX_W-1:0] rd_word_s1;
	logic                      rd_vld_s1;
	logic [IDX_W-1:0]          rd_addr_q;

	logic [31:0]               idx_ext;
	logic [IDX_W-1:0]          wr_addr;
	logic                      wr_en;

	bup_pkg::coord_t point_q   [NA];
	bup_pkg::coord_t acc_min_q [NA];
	bup_pkg::coord_t acc_max_q [NA];
	logic            kind_q;
	logic            hit_q;
	logic            first_q;

	bup_pkg::coord_t a       [NA];
	bup_pkg::coord_t b       [NA];
	bup_pkg::coord_t new_min [NA];
	bup_pkg::coord_t new_max [NA];
	logic [NA-1:0]   in_ax;
	logic [NA-1:0]   ext_ne;
	logic            box_hit;
	logic [bup_pkg::DIM_W-1:0] dim;

	logic                      out_vld_q;
	logic                      out_inside_q;
	bup_pkg::coord_t           out_min_q [NA];
	bup_pkg::coord_t           out_max_q [NA];
	logic [bup_pkg::DIM_W-1:0] out_dim_q;

	// A count above the table depth uses the whole table.
	assign nb = (32'(box_count_q) > MAX_BOXES) ? CNT_W'(MAX_BOXES) : CNT_W'(box_count_q);

	assign idx_ext = 32'(s_tdata[bup_pkg::IN_IDX_LSB +: bup_pkg::IDX_IN_W]);
	assign wr_addr = idx_ext[IDX_W-1:0];
	assign wr_en   = ctl.load && (idx_ext < MAX_BOXES);

	assign stat.nb_zero  = (nb == '0);
	assign stat.rd_last  = (CNT_W'(rd_addr_q) == (nb - CNT_W'(1)));
	assign stat.out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q <= '0;
		end else if (cfg_wen) begin
			box_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= s_tdata[bup_pkg::IN_BOX_LSB +: bup_pkg::BOX_W];
		end
		if (ctl.rd_en) begin
			rd_word_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			rd_vld_s1 <= ctl.rd_en;
			if (ctl.start) begin
				rd_addr_q <= '0;
			end else if (ctl.rd_en) begin
				rd_addr_q <= rd_addr_q + IDX_W'(1);
			end
		end
	end

	// Each axis is tested against both orderings of start and end in parallel.
	always_comb begin
		for (int n = 0; n < NA; n++) begin
			a[n] = rd_word_s1[(2 * n) * CW +: CW];
			b[n] = rd_word_s1[(2 * n + 1) * CW +: CW];
			in_ax[n] = ((point_q[n] >= a[n]) && (point_q[n] <= b[n])) ||
			           ((point_q[n] >= b[n]) && (point_q[n] <= a[n]));
			if (a[n] <= b[n]) begin
				new_min[n] = (first_q || (a[n] < acc_min_q[n])) ? a[n] : acc_min_q[n];
				new_max[n] = (first_q || (b[n] > acc_max_q[n])) ? b[n] : acc_max_q[n];
			end else begin
				new_min[n] = (first_q || (b[n] < acc_min_q[n])) ? b[n] : acc_min_q[n];
				new_max[n] = (first_q || (a[n] > acc_max_q[n])) ? a[n] : acc_max_q[n];
			end
			ext_ne[n] = (acc_min_q[n] != acc_max_q[n]);
		end
		box_hit = &in_ax;
		dim = {1'b0, ext_ne[0]} + {1'b0, ext_ne[1]} + {1'b0, ext_ne[2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= 1'b0;
			hit_q   <= 1'b0;
			first_q <= 1'b1;
		end else if (ctl.start) begin
			kind_q  <= ctl.kind_bound;
			hit_q   <= 1'b0;
			first_q <= 1'b1;
		end else if (rd_vld_s1) begin
			hit_q   <= hit_q || box_hit;
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int n = 0; n < NA; n++) begin
				point_q[n]   <= s_tdata[bup_pkg::IN_PT_LSB + n * CW +: CW];
				acc_min_q[n] <= '0;
				acc_max_q[n] <= '0;
			end
		end else if (rd_vld_s1) begin
			for (int n = 0; n < NA; n++) begin
				acc_min_q[n] <= new_min[n];
				acc_max_q[n] <= new_max[n];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_inside_q <= !kind_q && hit_q;
			out_dim_q    <= kind_q ? dim : '0;
			for (int n = 0; n < NA; n++) begin
				out_min_q[n] <= kind_q ? acc_min_q[n] : '0;
				out_max_q[n] <= kind_q ? acc_max_q[n] : '0;
			end
		end
	end

	assign m_tvalid = out_vld_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[bup_pkg::OUT_INSIDE] = out_inside_q;
		for (int n = 0; n < NA; n++) begin
			m_tdata[bup_pkg::OUT_BND_LSB + (2 * n) * CW +: CW]     = out_min_q[n];
			m_tdata[bup_pkg::OUT_BND_LSB + (2 * n + 1) * CW +: CW] = out_max_q[n];
		end
		m_tdata[bup_pkg::OUT_DIM_LSB +: bup_pkg::DIM_W] = out_dim_q;
	end

endmodule

// ----- sv/bup_ctrl.sv -----
// Controller state machine that sequences loads, table walks and result hand-off.
module bup_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [bup_pkg::CMD_W-1:0] s_tuser,
	input  bup_pkg::bup_stat_t        stat,
	output bup_pkg::bup_ctl_t         ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t        state_q;
	state_t        state_d;
	bup_pkg::cmd_t cmd;
	logic          accept;

	assign cmd      = bup_pkg::cmd_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						bup_pkg::CMD_LOAD: begin
							ctl.load = 1'b1;
						end
						bup_pkg::CMD_POINT, bup_pkg::CMD_BOUND: begin
							ctl.start      = 1'b1;
							ctl.kind_bound = (cmd == bup_pkg::CMD_BOUND);
							state_d        = stat.nb_zero ? ST_EMIT : ST_READ;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				ctl.rd_en = 1'b1;
				if (stat.rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last entry read is folded into the accumulators here.
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/box_union_point_test.sv -----
// Top level of the point test against a union of axis-aligned boxes.
//
// Requests arrive on the s_ group; tuser carries the command (load box, point
// query, bounding box query) and tdata the entry index, box corners and point.
// A load writes one table entry and gives no result. Each query gives one
// result on the m_ group: the inside flag for a point query, or the union
// bounding box and the count of axes with nonzero extent for a bound query.
// Unknown commands are dropped.
// The register box_count, written through cfg_wen and cfg_wdata, selects how
// many entries from entry zero take part; the user is to write it only while
// the block is idle, and the block itself does not enforce this. A query steps
// through the request, one table read per box in use over the single read port
// of the box memory, a step to fold in the last entry and a step to load the
// result register; with no boxes it goes from the request to the result load.
// The result register lets the next request in while a result waits; when the
// receiver stalls, the following query holds in its last step until the
// register frees up.
// Reset clears box_count and all control state; table entries stay undefined
// until loaded.
module box_union_point_test #(
	parameter int MAX_BOXES = bup_pkg::MAX_BOXES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// s_tdata from bit 0: box_index, start_x, end_x, start_y, end_y, start_z,
	// end_z, point_x, point_y, point_z, zero fill.
	input  logic [bup_pkg::IN_W-1:0]   s_tdata,
	// s_tuser: cmd.
	input  logic [bup_pkg::CMD_W-1:0]  s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// m_tdata from bit 0: inside_res, bound_min_x, bound_max_x, bound_min_y,
	// bound_max_y, bound_min_z, bound_max_z, dimension, zero fill.
	output logic [bup_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       cfg_wen,
	input  logic [bup_pkg::CFG_W-1:0]  cfg_wdata
);

	bup_pkg::bup_ctl_t  ctl;
	bup_pkg::bup_stat_t stat;

	bup_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.ctl      (ctl)
	);

	bup_datapath #(
		.MAX_BOXES (MAX_BOXES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.ctl       (ctl),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- sv/bup_checker.sv -----
// Port-level checks of the box union point test block and their binding.
module bup_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [bup_pkg::CMD_W-1:0]  s_tuser,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [bup_pkg::OUT_W-1:0]  m_tdata
);

	localparam int CW = bup_pkg::COORD_W;
	localparam int BL = bup_pkg::OUT_BND_LSB;

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A point hit carries no bounding box.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[bup_pkg::OUT_INSIDE] |->
		m_tdata[bup_pkg::OUT_W-1:BL] == '0)
		else $error("point result carries bounds");

	// The dimension counts the axes with nonzero extent.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
		32'(m_tdata[bup_pkg::OUT_DIM_LSB +: bup_pkg::DIM_W]) == $countones({
			m_tdata[BL + 0 * CW +: CW] != m_tdata[BL + 1 * CW +: CW],
			m_tdata[BL + 2 * CW +: CW] != m_tdata[BL + 3 * CW +: CW],
			m_tdata[BL + 4 * CW +: CW] != m_tdata[BL + 5 * CW +: CW]}))
		else $error("dimension disagrees with bounds");

	// Every bounding box is ordered min to max.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
		($signed(m_tdata[BL + 0 * CW +: CW]) <= $signed(m_tdata[BL + 1 * CW +: CW])) &&
		($signed(m_tdata[BL + 2 * CW +: CW]) <= $signed(m_tdata[BL + 3 * CW +: CW])) &&
		($signed(m_tdata[BL + 4 * CW +: CW]) <= $signed(m_tdata[BL + 5 * CW +: CW])))
		else $error("bounding box out of order");

	// A load request never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == bup_pkg::CMD_LOAD) && !m_tvalid |=> !m_tvalid)
		else $error("load produced a result");

endmodule

bind box_union_point_test bup_checker u_bup_checker (.*);

// ----- tb/sv/box_union_point_test_test.sv -----
// Testbench for box_union_point_test: loads, point and bounding box queries checked against a model.
`timescale 1ns / 1ps

module box_union_point_test_test;

	localparam int NBOX = bup_pkg::MAX_BOXES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam logic [bup_pkg::CMD_W-1:0] CMD_BAD = 2'd3;

	typedef logic [bup_pkg::IDX_IN_W-1:0] idx_t;
	typedef logic [bup_pkg::CFG_W-1:0]    count_t;

	typedef struct packed {
		logic [bup_pkg::CMD_W-1:0]    cmd;
		logic [bup_pkg::IDX_IN_W-1:0] idx;
		bup_pkg::coord_t [5:0]        corner;  // start_x, end_x, start_y, end_y, start_z, end_z
		bup_pkg::coord_t [2:0]        pt;
	} request_t;

	typedef struct packed {
		logic                  inside_res;
		bup_pkg::coord_t [5:0] bnd;  // min_x, max_x, min_y, max_y, min_z, max_z
		logic [1:0]            dim;
	} answer_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [bup_pkg::IN_W-1:0]   s_tdata = '0;
	logic [bup_pkg::CMD_W-1:0]  s_tuser = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [bup_pkg::OUT_W-1:0]  m_tdata;
	logic                       cfg_wen = 1'b0;
	logic [bup_pkg::CFG_W-1:0]  cfg_wdata = '0;

	// Model of the block state.
	bup_pkg::coord_t            box_mem [NBOX][6];
	logic [bup_pkg::CFG_W-1:0]  box_limit = '0;

	request_t          request_q [$];
	answer_t           expected_answers [$];
	request_t          cur_req;
	int                n_queued = 0;
	int                n_accepted = 0;
	int                idle_odds = 0;
	int                send_gap = 0;
	int                hold_gap = 0;
	int                mismatch_count = 0;
	int                cycle_count = 0;
	string             bound_field [6] = '{"bound_min_x", "bound_max_x", "bound_min_y",
		"bound_max_y", "bound_min_z", "bound_max_z"};

	box_union_point_test dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	task automatic report_mismatch(string msg);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic logic [bup_pkg::IN_W-1:0] pack_request(request_t r);
		logic [bup_pkg::IN_W-1:0] d;
		d = '0;
		d[bup_pkg::IN_IDX_LSB +: bup_pkg::IDX_IN_W] = r.idx;
		for (int n = 0; n < 6; n++)
			d[bup_pkg::IN_BOX_LSB + n * bup_pkg::COORD_W +: bup_pkg::COORD_W] = r.corner[n];
		for (int n = 0; n < 3; n++)
			d[bup_pkg::IN_PT_LSB + n * bup_pkg::COORD_W +: bup_pkg::COORD_W] = r.pt[n];
		return d;
	endfunction

	// Updates the table copy for a load and queues the answer of a query.
	task automatic predict_box_answer(request_t r);
		answer_t ans;
		int nb;
		logic hit, ok;
		bup_pkg::coord_t va, vb, lo, hi, p;
		bup_pkg::coord_t bmin [3];
		bup_pkg::coord_t bmax [3];
		ans = '0;
		nb = (box_limit > NBOX) ? NBOX : int'(box_limit);
		case (r.cmd)
			bup_pkg::CMD_LOAD: begin
				for (int n = 0; n < 6; n++)
					box_mem[r.idx][n] = r.corner[n];
			end
			bup_pkg::CMD_POINT: begin
				hit = 1'b0;
				for (int i = 0; i < nb; i++) begin
					ok = 1'b1;
					for (int n = 0; n < 3; n++) begin
						va = box_mem[i][2 * n];
						vb = box_mem[i][2 * n + 1];
						lo = (va < vb) ? va : vb;
						hi = (va < vb) ? vb : va;
						p = r.pt[n];
						if (p < lo || p > hi)
							ok = 1'b0;
					end
					hit = hit | ok;
				end
				ans.inside_res = hit;
				expected_answers = {expected_answers, ans};
			end
			bup_pkg::CMD_BOUND: begin
				for (int n = 0; n < 3; n++) begin
					bmin[n] = '0;
					bmax[n] = '0;
				end
				for (int i = 0; i < nb; i++) begin
					for (int n = 0; n < 3; n++) begin
						va = box_mem[i][2 * n];
						vb = box_mem[i][2 * n + 1];
						lo = (va <= vb) ? va : vb;
						hi = (va <= vb) ? vb : va;
						if (i == 0 || lo < bmin[n])
							bmin[n] = lo;
						if (i == 0 || hi > bmax[n])
							bmax[n] = hi;
					end
				end
				for (int n = 0; n < 3; n++) begin
					ans.bnd[2 * n] = bmin[n];
					ans.bnd[2 * n + 1] = bmax[n];
					if (bmin[n] != bmax[n])
						ans.dim = ans.dim + 2'd1;
				end
				expected_answers = {expected_answers, ans};
			end
			default: ;
		endcase
	endtask

	// Request driver: presents queued requests with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_box_answer(cur_req);
				n_accepted++;
			end
			if (s_tvalid && !s_tready) begin
				// Hold the request until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
				send_gap = $urandom_range(1, 17) - 1;
				s_tvalid <= 1'b0;
			end else if (request_q.size() > 0) begin
				cur_req = request_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_req.cmd;
				s_tdata <= pack_request(cur_req);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor: random stalls, and every accepted result checked in order.
	always @(posedge clk or negedge arst_n) begin : watch_results
		answer_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.inside_res = m_tdata[bup_pkg::OUT_INSIDE];
				for (int n = 0; n < 6; n++)
					got.bnd[n] = m_tdata[bup_pkg::OUT_BND_LSB + n * bup_pkg::COORD_W +:
						bup_pkg::COORD_W];
				got.dim = m_tdata[bup_pkg::OUT_DIM_LSB +: bup_pkg::DIM_W];
				if (expected_answers.size() == 0) begin
					report_mismatch("result with no query waiting");
				end else begin
					want = expected_answers.pop_front();
					if (got.inside_res !== want.inside_res)
						report_mismatch($sformatf("inside_res got %0d expected %0d",
							got.inside_res, want.inside_res));
					for (int n = 0; n < 6; n++)
						if (got.bnd[n] !== want.bnd[n])
							report_mismatch($sformatf("%s got %0d expected %0d",
								bound_field[n], $signed(got.bnd[n]), $signed(want.bnd[n])));
					if (got.dim !== want.dim)
						report_mismatch($sformatf("dimension got %0d expected %0d",
							got.dim, want.dim));
				end
			end
			if (hold_gap > 0) begin
				hold_gap--;
				m_tready <= 1'b0;
			end else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
				hold_gap = $urandom_range(1, 17) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic bup_pkg::coord_t pick_coord();
		case ($urandom_range(0, 7))
			0: return bup_pkg::coord_t'(32'h8000_0000);
			1: return bup_pkg::coord_t'(32'h7FFF_FFFF);
			2: return '0;
			3, 4: return bup_pkg::coord_t'($urandom);
			default: return bup_pkg::coord_t'(int'($urandom_range(0, 8000000)) - 4000000);
		endcase
	endfunction

	function automatic request_t make_noise(logic [bup_pkg::CMD_W-1:0] cmd);
		request_t r;
		r.cmd = cmd;
		r.idx = idx_t'($urandom);
		for (int n = 0; n < 6; n++)
			r.corner[n] = $urandom;
		for (int n = 0; n < 3; n++)
			r.pt[n] = $urandom;
		return r;
	endfunction

	function automatic request_t make_load(logic [bup_pkg::IDX_IN_W-1:0] idx);
		request_t r;
		bup_pkg::coord_t a;
		r = make_noise(bup_pkg::CMD_LOAD);
		r.idx = idx;
		for (int n = 0; n < 3; n++) begin
			a = pick_coord();
			r.corner[2 * n] = a;
			case ($urandom_range(0, 5))
				0: r.corner[2 * n + 1] = a;
				1: r.corner[2 * n + 1] = pick_coord();
				default: r.corner[2 * n + 1] =
					bup_pkg::coord_t'(a + (int'($urandom_range(0, 2097152)) - 1048576));
			endcase
		end
		return r;
	endfunction

	// A point on, just outside or inside one of the boxes in use, or a random point when none is in use.
	function automatic request_t make_point_near();
		request_t r;
		int nb, pick;
		longint lo, hi, v, a, b;
		r = make_noise(bup_pkg::CMD_POINT);
		nb = (box_limit > NBOX) ? NBOX : int'(box_limit);
		if (nb == 0)
			return r;
		pick = $urandom_range(0, nb - 1);
		for (int n = 0; n < 3; n++) begin
			a = box_mem[pick][2 * n];
			b = box_mem[pick][2 * n + 1];
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			case ($urandom_range(0, 7))
				0: v = lo;
				1: v = hi;
				2: v = lo - 1;
				3: v = hi + 1;
				default: v = lo + (longint'($urandom) % (hi - lo + 1));
			endcase
			r.pt[n] = bup_pkg::coord_t'(v[31:0]);
		end
		return r;
	endfunction

	task automatic queue_request(request_t r);
		request_q = {request_q, r};
		n_queued++;
	endtask

	function automatic request_t make_point(bup_pkg::coord_t x, bup_pkg::coord_t y,
			bup_pkg::coord_t z);
		request_t r;
		r = make_noise(bup_pkg::CMD_POINT);
		r.pt[0] = x;
		r.pt[1] = y;
		r.pt[2] = z;
		return r;
	endfunction

	function automatic request_t make_box(bup_pkg::coord_t sx, bup_pkg::coord_t ex,
			bup_pkg::coord_t sy, bup_pkg::coord_t ey, bup_pkg::coord_t sz, bup_pkg::coord_t ez);
		request_t r;
		r = make_noise(bup_pkg::CMD_LOAD);
		r.idx = '0;
		r.corner[0] = sx;
		r.corner[1] = ex;
		r.corner[2] = sy;
		r.corner[3] = ey;
		r.corner[4] = sz;
		r.corner[5] = ez;
		return r;
	endfunction

	// Holds the sender until every request is taken and every result is in,
	// then lets a full query time pass so no load is still being written.
	task automatic settle();
		while (n_accepted != n_queued || expected_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [bup_pkg::CFG_W-1:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		box_limit = v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic random_phase(int count);
		int real_items, r;
		real_items = 0;
		while (real_items < count) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				queue_request(make_load(idx_t'($urandom)));
			else if (r < 55)
				queue_request(make_point_near());
			else if (r < 68)
				queue_request(make_point(pick_coord(), pick_coord(), pick_coord()));
			else if (r < 92)
				queue_request(make_noise(bup_pkg::CMD_BOUND));
			else
				queue_request(make_noise(CMD_BAD));
			if (r < 92)
				real_items++;
		end
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int odds_choice [4];
		odds_choice = '{0, 10, 30, 60};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		idle_odds = 20;

		// With no boxes in use both queries answer all zero.
		write_count(5'd0);
		queue_request(make_point(pick_coord(), pick_coord(), pick_coord()));
		queue_request(make_noise(bup_pkg::CMD_BOUND));
		queue_request(make_noise(CMD_BAD));
		// Entry zero spans the whole x range with its corners reversed, is flat
		// in y at 5.0, and runs from 100.0 down to -100.0 in z.
		queue_request(make_box(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0005_0000,
			32'sh0005_0000, 32'sh0064_0000, -32'sh0064_0000));
		for (int i = 1; i < NBOX; i++)
			queue_request(make_load(idx_t'(i)));
		settle();

		write_count(5'd1);
		queue_request(make_point(32'sh8000_0000, 32'sh0005_0000, 32'sh0000_0000));
		queue_request(make_point(32'sh7FFF_FFFF, 32'sh0005_0000, -32'sh0064_0000));
		queue_request(make_point(32'sh0000_0000, 32'sh0005_0001, 32'sh0000_0000));
		queue_request(make_point(32'sh0000_0000, 32'sh0005_0000, 32'sh0064_0001));
		queue_request(make_point(32'sh0000_0000, 32'sh0005_0000, -32'sh0064_0001));
		queue_request(make_noise(bup_pkg::CMD_BOUND));
		// A single point as a box: no extent on any axis.
		queue_request(make_box(-32'sh0007_8000, -32'sh0007_8000, -32'sh0007_8000,
			-32'sh0007_8000, -32'sh0007_8000, -32'sh0007_8000));
		queue_request(make_noise(bup_pkg::CMD_BOUND));
		queue_request(make_point(-32'sh0007_8000, -32'sh0007_8000, -32'sh0007_8000));
		queue_request(make_point(-32'sh0007_8000, -32'sh0007_7FFF, -32'sh0007_8000));
		queue_request(make_box(32'sh0000_0000, 32'sh0001_0000, 32'sh0002_0000,
			32'sh0002_0000, 32'sh0003_0000, 32'sh0003_0000));
		queue_request(make_noise(bup_pkg::CMD_BOUND));
		settle();

		write_count(5'd16);
		queue_request(make_noise(bup_pkg::CMD_BOUND));
		for (int i = 0; i < 4; i++)
			queue_request(make_point_near());
		settle();

		// A count above the table size uses the whole table.
		write_count(5'd31);
		queue_request(make_noise(bup_pkg::CMD_BOUND));
		for (int i = 0; i < 4; i++)
			queue_request(make_point_near());
		settle();

		for (int ph = 0; ph < 7; ph++) begin
			idle_odds = odds_choice[$urandom_range(0, 3)];
			write_count(count_t'($urandom_range(0, 31)));
			random_phase(70);
			settle();
		end

		// Last stretch runs without any idling.
		idle_odds = 0;
		write_count(count_t'($urandom_range(1, 16)));
		random_phase(90);
		settle();

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
